FILE: src/slm_pkg.sv
// Package with the request and result types and the mode codes of the sorted list merge.
package slm_pkg;

	localparam int TOTAL_W = 7;
	localparam int VALUE_W = 32;

	localparam logic [1:0] MODE_PUSH_LEFT  = 2'd0;
	localparam logic [1:0] MODE_PUSH_RIGHT = 2'd1;
	localparam logic [1:0] MODE_MERGE      = 2'd2;

	typedef struct packed {
		logic [1:0]                mode;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value_res;
		logic [TOTAL_W-1:0]        total;
		logic                      last;
		logic                      overflow;
	} res_t;

endpackage

FILE: src/sorted_list_merge.sv
// Two-way merge of two ascending lists held in two synchronous memories.
//
// The block keeps a left and a right list of up to LIST_DEPTH signed 32-bit
// elements, each in its own memory with a registered read. A push request
// appends its value to the end of the chosen list; a push to a full list is
// dropped and sets the overflow flag. A merge request walks both lists from
// the front and emits every stored element in ascending signed order, taking
// the left element first on a tie. Each merged element takes two steps: a
// read state that reads both list heads from the memories and a pick state
// that compares them and loads the result register, waiting while the result
// side stalls; the request channel stays stalled for the whole merge. Every
// result carries the total element count and the overflow flag, and the final
// one has last set. When the merge ends both lists are empty and the overflow
// flag is cleared; a merge of two empty lists emits nothing. Mode 3 is
// ignored. Pushes are accepted again as soon as the final result sits in the
// output register, even while it waits.
module sorted_list_merge #(
	parameter int LIST_DEPTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  slm_pkg::req_t  req,
	output logic           res_valid,
	input  logic           res_stall,
	output slm_pkg::res_t  res
);
	import slm_pkg::*;

	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_PICK
	} state_t;

	state_t state_q;

	// List storage. Entries above the fill count are never used.
	logic [VALUE_W-1:0] left_mem  [LIST_DEPTH];
	logic [VALUE_W-1:0] right_mem [LIST_DEPTH];

	logic [CW-1:0] left_cnt_q;
	logic [CW-1:0] right_cnt_q;
	logic          dropped_q;

	// Read positions of the merge walk.
	logic [CW-1:0] left_idx_q;
	logic [CW-1:0] right_idx_q;

	// Head elements as read from the memories.
	logic signed [VALUE_W-1:0] left_head_s1;
	logic signed [VALUE_W-1:0] right_head_s1;

	logic res_valid_q;
	res_t res_q;

	logic accept;
	logic left_full;
	logic right_full;
	logic left_wr;
	logic right_wr;
	logic out_free;
	logic res_load;
	logic left_left;
	logic right_left;
	logic take_left;
	logic [TOTAL_W-1:0] total;
	logic [TOTAL_W-1:0] emitted_next;
	logic is_last;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;

	assign left_full  = (left_cnt_q == CW'(LIST_DEPTH));
	assign right_full = (right_cnt_q == CW'(LIST_DEPTH));
	assign left_wr    = accept && (req.mode == MODE_PUSH_LEFT) && !left_full;
	assign right_wr   = accept && (req.mode == MODE_PUSH_RIGHT) && !right_full;

	assign out_free = !res_valid_q || !res_stall;

	// The result register takes a new element whenever the pick stage finds it free.
	assign res_load = (state_q == ST_PICK) && out_free;

	// A list still has elements while its read position is below its count.
	assign left_left  = (left_idx_q < left_cnt_q);
	assign right_left = (right_idx_q < right_cnt_q);

	always_comb begin
		if (!left_left) begin
			take_left = 1'b0;
		end else if (!right_left) begin
			take_left = 1'b1;
		end else begin
			take_left = (left_head_s1 <= right_head_s1);
		end
	end

	assign total        = TOTAL_W'(left_cnt_q) + TOTAL_W'(right_cnt_q);
	assign emitted_next = TOTAL_W'(left_idx_q) + TOTAL_W'(right_idx_q) + TOTAL_W'(1);
	assign is_last      = (emitted_next == total);

	// Memories are written only by pushes while idle and the registered heads are
	// used only during a merge, so a read that meets a write is never used.
	always_ff @(posedge clk) begin
		if (left_wr) begin
			left_mem[left_cnt_q[AW-1:0]] <= req.value;
		end
		left_head_s1 <= left_mem[left_idx_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (right_wr) begin
			right_mem[right_cnt_q[AW-1:0]] <= req.value;
		end
		right_head_s1 <= right_mem[right_idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			left_cnt_q  <= '0;
			right_cnt_q <= '0;
			dropped_q   <= 1'b0;
			left_idx_q  <= '0;
			right_idx_q <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						priority if (req.mode == MODE_PUSH_LEFT) begin
							if (left_full) begin
								dropped_q <= 1'b1;
							end else begin
								left_cnt_q <= left_cnt_q + CW'(1);
							end
						end else if (req.mode == MODE_PUSH_RIGHT) begin
							if (right_full) begin
								dropped_q <= 1'b1;
							end else begin
								right_cnt_q <= right_cnt_q + CW'(1);
							end
						end else if (req.mode == MODE_MERGE) begin
							left_idx_q  <= '0;
							right_idx_q <= '0;
							if (total == '0) begin
								dropped_q <= 1'b0;
							end else begin
								state_q <= ST_READ;
							end
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_PICK;
				end
				ST_PICK: begin
					if (out_free) begin
						res_q.value_res   <= take_left ? left_head_s1 : right_head_s1;
						res_q.total       <= total;
						res_q.last        <= is_last;
						res_q.overflow    <= dropped_q;
						if (take_left) begin
							left_idx_q <= left_idx_q + CW'(1);
						end else begin
							right_idx_q <= right_idx_q + CW'(1);
						end
						if (is_last) begin
							left_cnt_q  <= '0;
							right_cnt_q <= '0;
							dropped_q   <= 1'b0;
							state_q     <= ST_IDLE;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
